/* sv/stt_pkg.sv */
// Shared types and constants for the source text tokenizer.
package stt_pkg;

  localparam int unsigned STT_QUEUE_DEPTH = 4;

  localparam int unsigned LINE_W = 24;
  localparam int unsigned COL_W  = 16;
  localparam int unsigned NUM_W  = 64;

  localparam logic [LINE_W-1:0] LINE_MAX = '1;
  localparam logic [COL_W-1:0]  COL_MAX  = '1;

  typedef enum logic [3:0] {
    KIND_CHAR  = 4'd0,
    KIND_EOF   = 4'd1,
    KIND_IDEND = 4'd2,
    KIND_NUM   = 4'd3,
    KIND_DOT   = 4'd4,
    KIND_COMMA = 4'd5,
    KIND_SEMI  = 4'd6,
    KIND_EQ    = 4'd7,
    KIND_LBR   = 4'd8,
    KIND_RBR   = 4'd9,
    KIND_IN    = 4'd10,
    KIND_OUT   = 4'd11,
    KIND_BLOCK = 4'd12,
    KIND_BAD   = 4'd13
  } kind_t;

  typedef enum logic [2:0] {
    CLS_EOF    = 3'd0,
    CLS_SPACE  = 3'd1,
    CLS_DIGIT  = 3'd2,
    CLS_LETTER = 3'd3,
    CLS_PUNCT  = 3'd4,
    CLS_BAD    = 3'd5
  } cls_t;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'b001,
    MODE_NUM   = 3'b010,
    MODE_IDENT = 3'b100
  } mode_t;

  typedef enum logic [3:0] {
    TRK_NONE  = 4'd0,
    TRK_I     = 4'd1,
    TRK_IN    = 4'd2,
    TRK_O     = 4'd3,
    TRK_OU    = 4'd4,
    TRK_OUT   = 4'd5,
    TRK_B     = 4'd6,
    TRK_BL    = 4'd7,
    TRK_BLO   = 4'd8,
    TRK_BLOC  = 4'd9,
    TRK_BLOCK = 4'd10
  } trk_t;

  typedef struct packed {
    cls_t              cls;
    kind_t             kind;
    logic [7:0]        ch;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  col;
  } cmd_t;

  typedef struct packed {
    kind_t             kind;
    logic [NUM_W-1:0]  num;
    logic [7:0]        ch;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  col;
    logic              last;
  } res_t;

endpackage

/* sv/stt_front.sv */
// Front end: accepts bytes, tracks line and column, classifies each request.
module stt_front import stt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_text_byte,
  input  logic       in_end_mark,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);

  logic [LINE_W-1:0] line_r, line_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic              is_nl;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign is_nl    = !in_end_mark && (in_text_byte == 8'h0A);

  always_comb begin
    line_nxt = line_r;
    col_nxt  = col_r;
    if (is_nl) begin
      if (line_r != LINE_MAX) line_nxt = line_r + 1'b1;
      col_nxt = '0;
    end else if (col_r != COL_MAX) begin
      col_nxt = col_r + 1'b1;
    end
  end

  always_comb begin
    q_cmd.ch   = in_text_byte;
    q_cmd.line = line_nxt;
    q_cmd.col  = col_nxt;
    q_cmd.kind = KIND_BAD;
    q_cmd.cls  = CLS_BAD;
    if (in_end_mark) begin
      q_cmd.cls = CLS_EOF;
    end else if (in_text_byte == 8'h20 ||
                 (in_text_byte >= 8'h09 && in_text_byte <= 8'h0D)) begin
      q_cmd.cls = CLS_SPACE;
    end else if (in_text_byte >= 8'h30 && in_text_byte <= 8'h39) begin
      q_cmd.cls = CLS_DIGIT;
    end else if ((in_text_byte >= 8'h61 && in_text_byte <= 8'h7A) ||
                 (in_text_byte >= 8'h41 && in_text_byte <= 8'h5A) ||
                 in_text_byte == 8'h5F) begin
      q_cmd.cls = CLS_LETTER;
    end else begin
      q_cmd.cls = CLS_PUNCT;
      unique case (in_text_byte)
        8'h2E:   q_cmd.kind = KIND_DOT;
        8'h2C:   q_cmd.kind = KIND_COMMA;
        8'h3B:   q_cmd.kind = KIND_SEMI;
        8'h3D:   q_cmd.kind = KIND_EQ;
        8'h7B:   q_cmd.kind = KIND_LBR;
        8'h7D:   q_cmd.kind = KIND_RBR;
        default: q_cmd.cls  = CLS_BAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r <= LINE_W'(1);
      col_r  <= '0;
    end else if (q_push) begin
      line_r <= line_nxt;
      col_r  <= col_nxt;
    end
  end

endmodule

/* sv/stt_fifo.sv */
// Short request queue between the front end and the scanner.
module stt_fifo import stt_pkg::*; #(
  parameter int unsigned DEPTH = STT_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic nempty,
  output cmd_t pop_cmd
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign nempty  = (cnt_r != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && nempty;
  assign pop_cmd = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    if (do_pop)  rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_cmd;
  end

endmodule

/* sv/stt_back.sv */
// Scanner back end: number, identifier and keyword state, result staging.
module stt_back import stt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_nempty,
  input  cmd_t              q_cmd,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [3:0]        out_token_kind,
  output logic [NUM_W-1:0]  out_number_value,
  output logic [7:0]        out_char_value,
  output logic [LINE_W-1:0] out_start_line,
  output logic [COL_W-1:0]  out_start_column,
  output logic              out_last_of_run
);

  mode_t             mode_r, mode_nxt;
  logic [NUM_W-1:0]  acc_r, acc_nxt;
  trk_t              trk_r, trk_nxt;
  logic [LINE_W-1:0] tsl_r, tsl_nxt;
  logic [COL_W-1:0]  tsc_r, tsc_nxt;
  res_t              out_r, out_nxt, pend_r, pend_nxt;
  logic              out_v_r, out_v_nxt, pend_v_r, pend_v_nxt;
  res_t              res_a, res_b;
  logic              has_a, has_b, cont, ready;
  logic [NUM_W-1:0]  acc_x10;
  logic [NUM_W-1:0]  dig;

  function automatic trk_t trk_first(input logic [7:0] c);
    trk_t t;
    t = TRK_NONE;
    if (c == 8'h69) t = TRK_I;
    else if (c == 8'h6F) t = TRK_O;
    else if (c == 8'h62) t = TRK_B;
    return t;
  endfunction

  function automatic trk_t trk_step(input trk_t t, input logic [7:0] c);
    trk_t r;
    r = TRK_NONE;
    if (t == TRK_I && c == 8'h6E) r = TRK_IN;
    else if (t == TRK_O && c == 8'h75) r = TRK_OU;
    else if (t == TRK_OU && c == 8'h74) r = TRK_OUT;
    else if (t == TRK_B && c == 8'h6C) r = TRK_BL;
    else if (t == TRK_BL && c == 8'h6F) r = TRK_BLO;
    else if (t == TRK_BLO && c == 8'h63) r = TRK_BLOC;
    else if (t == TRK_BLOC && c == 8'h6B) r = TRK_BLOCK;
    return r;
  endfunction

  assign ready   = !pend_v_r && (!out_v_r || !out_stall);
  assign q_pop   = q_nempty && ready;
  assign dig     = {{(NUM_W-4){1'b0}}, q_cmd.ch[3:0]};
  assign acc_x10 = {acc_r[NUM_W-4:0], 3'b000} + {acc_r[NUM_W-2:0], 1'b0};

  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    trk_nxt  = trk_r;
    tsl_nxt  = tsl_r;
    tsc_nxt  = tsc_r;
    has_a    = 1'b0;
    has_b    = 1'b0;
    cont     = 1'b0;
    res_a    = '{kind: KIND_NUM, num: acc_r, ch: 8'h00, line: tsl_r, col: tsc_r, last: 1'b0};
    res_b    = '{kind: KIND_EOF, num: '0, ch: 8'h00, line: q_cmd.line, col: q_cmd.col,
                 last: 1'b1};

    unique case (mode_r)
      MODE_NUM: begin
        if (q_cmd.cls == CLS_DIGIT) begin
          acc_nxt = acc_x10 + dig;
          cont    = 1'b1;
        end else begin
          has_a = 1'b1;
        end
      end
      MODE_IDENT: begin
        if (q_cmd.cls == CLS_DIGIT || q_cmd.cls == CLS_LETTER) begin
          trk_nxt    = trk_step(trk_r, q_cmd.ch);
          cont       = 1'b1;
          has_b      = 1'b1;
          res_b.kind = KIND_CHAR;
          res_b.ch   = q_cmd.ch;
          res_b.line = tsl_r;
          res_b.col  = tsc_r;
        end else begin
          has_a     = 1'b1;
          res_a.num = '0;
          if (trk_r == TRK_IN) res_a.kind = KIND_IN;
          else if (trk_r == TRK_OUT) res_a.kind = KIND_OUT;
          else if (trk_r == TRK_BLOCK) res_a.kind = KIND_BLOCK;
          else res_a.kind = KIND_IDEND;
          trk_nxt = TRK_NONE;
        end
      end
      default: ;
    endcase

    if (!cont) begin
      mode_nxt = MODE_IDLE;
      unique case (q_cmd.cls)
        CLS_EOF: has_b = 1'b1;
        CLS_SPACE: ;
        CLS_DIGIT: begin
          mode_nxt = MODE_NUM;
          acc_nxt  = dig;
          tsl_nxt  = q_cmd.line;
          tsc_nxt  = q_cmd.col;
        end
        CLS_LETTER: begin
          mode_nxt   = MODE_IDENT;
          trk_nxt    = trk_first(q_cmd.ch);
          tsl_nxt    = q_cmd.line;
          tsc_nxt    = q_cmd.col;
          has_b      = 1'b1;
          res_b.kind = KIND_CHAR;
          res_b.ch   = q_cmd.ch;
        end
        CLS_PUNCT: begin
          has_b      = 1'b1;
          res_b.kind = q_cmd.kind;
        end
        CLS_BAD: begin
          has_b      = 1'b1;
          res_b.kind = KIND_BAD;
          res_b.ch   = q_cmd.ch;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_nxt    = out_r;
    pend_nxt   = pend_r;
    out_v_nxt  = out_v_r;
    pend_v_nxt = pend_v_r;
    priority if (q_pop) begin
      if (has_a && has_b) begin
        out_nxt    = res_a;
        pend_nxt   = res_b;
        out_v_nxt  = 1'b1;
        pend_v_nxt = 1'b1;
      end else if (has_a) begin
        out_nxt      = res_a;
        out_nxt.last = 1'b1;
        out_v_nxt    = 1'b1;
      end else if (has_b) begin
        out_nxt   = res_b;
        out_v_nxt = 1'b1;
      end else begin
        out_v_nxt = 1'b0;
      end
    end else if (pend_v_r && (!out_v_r || !out_stall)) begin
      out_nxt    = pend_r;
      out_v_nxt  = 1'b1;
      pend_v_nxt = 1'b0;
    end else if (out_v_r && !out_stall) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      acc_r    <= '0;
      trk_r    <= TRK_NONE;
      tsl_r    <= LINE_W'(1);
      tsc_r    <= '0;
      out_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      if (q_pop) begin
        mode_r <= mode_nxt;
        acc_r  <= acc_nxt;
        trk_r  <= trk_nxt;
        tsl_r  <= tsl_nxt;
        tsc_r  <= tsc_nxt;
      end
      out_v_r  <= out_v_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
  end

  assign out_valid        = out_v_r;
  assign out_token_kind   = out_r.kind;
  assign out_number_value = out_r.num;
  assign out_char_value   = out_r.ch;
  assign out_start_line   = out_r.line;
  assign out_start_column = out_r.col;
  assign out_last_of_run  = out_r.last;

endmodule

/* sv/source_text_tokenizer.sv */
// Top level of the source text tokenizer: front end, request queue, scanner.
//
//   channel  direction  handshake         payload
//   in_      input      in_valid/stall    text_byte, end_mark
//   out_     output     out_valid/stall   token_kind .. last_of_run
//
// One byte is taken per cycle while the queue has room; each request gives
// zero, one or two results, and the output register passes one result per
// cycle while out_stall is low; a byte that closes a token and opens another
// parks its second result in a pending register and holds off the queue.
// rst_n is synchronous; it resets position to line 1, column 0, idle scan.
// A stall on out_ fills the queue (QUEUE_DEPTH entries) before in_stall rises.
module source_text_tokenizer import stt_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = STT_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_text_byte,
  input  logic              in_end_mark,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [3:0]        out_token_kind,
  output logic [NUM_W-1:0]  out_number_value,
  output logic [7:0]        out_char_value,
  output logic [LINE_W-1:0] out_start_line,
  output logic [COL_W-1:0]  out_start_column,
  output logic              out_last_of_run
);

  logic q_full, q_push, q_pop, q_nempty;
  cmd_t push_cmd, pop_cmd;

  stt_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_text_byte (in_text_byte),
    .in_end_mark  (in_end_mark),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (push_cmd)
  );

  stt_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .nempty   (q_nempty),
    .pop_cmd  (pop_cmd)
  );

  stt_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_nempty         (q_nempty),
    .q_cmd            (pop_cmd),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_kind   (out_token_kind),
    .out_number_value (out_number_value),
    .out_char_value   (out_char_value),
    .out_start_line   (out_start_line),
    .out_start_column (out_start_column),
    .out_last_of_run  (out_last_of_run)
  );

endmodule

/* sv/stt_checker.sv */
// Port-level checks for the source text tokenizer, bound to the top level.
module stt_checker import stt_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic [3:0]        out_token_kind,
  input logic [NUM_W-1:0]  out_number_value,
  input logic [7:0]        out_char_value,
  input logic [LINE_W-1:0] out_start_line,
  input logic [COL_W-1:0]  out_start_column,
  input logic              out_last_of_run
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_token_kind) &&
      $stable(out_number_value) && $stable(out_char_value) &&
      $stable(out_start_line) && $stable(out_start_column) && $stable(out_last_of_run))
    else $error("stalled result changed");

  a_num_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind != KIND_NUM |-> out_number_value == '0)
    else $error("number value on non-number result");

  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind != KIND_CHAR && out_token_kind != KIND_BAD
      |-> out_char_value == 8'h00)
    else $error("character value on wrong result");

  a_first_of_two: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |->
      out_token_kind == KIND_NUM || out_token_kind == KIND_IDEND ||
      out_token_kind == KIND_IN || out_token_kind == KIND_OUT ||
      out_token_kind == KIND_BLOCK)
    else $error("only a closed token may precede another result");

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_start_line != '0)
    else $error("line number zero");

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (.*);
